FILE: rtl/ksl_pkg.sv
// ---------------------------------------------------------------------------
// ksl_pkg: shared types and constants for the keyframe span locator
// Status codes, wrap modes, register indexes, item kinds and divider types.
// ---------------------------------------------------------------------------
package ksl_pkg;

   localparam logic [1:0] WRAP_CLAMP  = 2'd0;
   localparam logic [1:0] WRAP_WRAP   = 2'd1;
   localparam logic [1:0] WRAP_MIRROR = 2'd2;
   localparam logic [1:0] WRAP_APPEND = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_ZERO  = 2'd2;

   localparam logic [0:0] CSR_WRAP_MODE = 1'd0;
   localparam logic [0:0] CSR_KEY_COUNT = 1'd1;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Divider width: numerator up to 49 bits (33-bit span shifted by 16)
   localparam int DIV_W = 49;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quo;
      logic [DIV_W-1:0] rem;
   } div_rsp_type;

endpackage

FILE: rtl/ksl_divider.sv
// ---------------------------------------------------------------------------
// ksl_divider: unsigned restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module ksl_divider
   import ksl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CW = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;

   // Shift in one numerator bit, subtract when it fits
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_W-1]} - {1'b0, den_ff};
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = CW'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_W]) begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff;

`ifndef SYNTHESIS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held two cycles");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !req.start) |-> cnt_ff != '0)
      else $error("divider busy with zero count");
`endif

endmodule

FILE: rtl/keyframe_span_locator_top.sv
// ---------------------------------------------------------------------------
// keyframe_span_locator_top: key table with wrapped-time span lookup
// A write item loads one key (time and flat flag) into a table memory with a
// write port and a read port and gives no result. A query item reads the first
// and last key in use, wraps the time by the wrap mode, bisects the table one
// probe per memory read and returns the key index with a Q0.16 fraction toward
// the next key. One item is worked at a time, and no new item is taken while a
// result waits to be taken; a query's run time is set by up to two passes
// through the shared bit-serial divider (cycle count and fraction) and by the
// search reads. The table needs no clearing pass after reset.
// ---------------------------------------------------------------------------
module keyframe_span_locator_top
   import ksl_pkg::*;
#(
   parameter int MAX_KEYS       = 64,
   parameter int SNAP_TOLERANCE = 1
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: key_slot[5:0], time_value[37:6], key_flat[38], zero pad[39]
   input  logic [39:0] req_tdata,
   // tuser: kind
   input  logic        req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: span_key[5:0], span_fraction[21:6], span_cycle[53:22],
   //        status[55:54]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_KEYS);
   localparam int NW = $clog2(MAX_KEYS + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD0   = 4'd1;
   localparam logic [3:0] S_RDN   = 4'd2;
   localparam logic [3:0] S_LEN   = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_WRAP  = 4'd5;
   localparam logic [3:0] S_SNAP  = 4'd6;
   localparam logic [3:0] S_SRCH  = 4'd7;
   localparam logic [3:0] S_SWAIT = 4'd8;
   localparam logic [3:0] S_K0    = 4'd9;
   localparam logic [3:0] S_K1    = 4'd10;
   localparam logic [3:0] S_FDIV  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   // Key table: time and flat flag in one word
   logic [32:0] key_mem [MAX_KEYS];
   logic [32:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   logic [1:0]    wrap_mode_ff;
   logic [NW-1:0] key_count_ff;
   logic [NW-1:0] csr_count_sat;

   logic [3:0]  state_ff, state_in;
   logic        out_valid_ff;
   logic [55:0] out_data_ff, out_data_in;

   logic signed [32:0] t_ff, t_in;          // query time
   logic signed [32:0] start_ff, start_in;  // first key
   logic signed [33:0] len_ff, len_in;      // curve length
   logic signed [34:0] d_ff, d_in;          // time offset
   logic signed [34:0] w_ff, w_in;          // wrapped time
   logic signed [32:0] k0_ff, k0_in;
   logic               flat_ff, flat_in;
   logic [NW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic signed [31:0] cycle_ff, cycle_in;

   div_req_type dreq;
   div_rsp_type drsp;

   logic [NW-1:0]      nsat;
   logic signed [34:0] q_s, r_s, off_v, diff_v;
   logic [DIV_W-1:0]   frac_q;
   logic signed [34:0] span_v;

   ksl_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign req_tready = (state_ff == S_IDLE) && !out_valid_ff;
   assign nsat       = key_count_ff;

   // Registers from the write port; count saturates at the table depth
   assign csr_count_sat = (32'(csr_wdata) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) :
                          NW'(csr_wdata);
   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_mode_ff <= WRAP_CLAMP;
         key_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WRAP_MODE: wrap_mode_ff <= csr_wdata[1:0];
            CSR_KEY_COUNT: key_count_ff <= csr_count_sat;
            default: ;
         endcase
      end
   end

   // Memory ports: write a key, and read the address the sequencer picks
   assign wr_en   = req_tvalid && req_tready && (req_tuser == KIND_WRITE) &&
                    ({26'd0, req_tdata[5:0]} < 32'(MAX_KEYS));
   assign wr_addr = AW'(req_tdata[5:0]);
   always_ff @(posedge clock) begin
      if (wr_en) key_mem[wr_addr] <= {req_tdata[38], req_tdata[37:6]};
      rd_data_ff <= key_mem[rd_addr];
   end

   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = '0;
         S_RD0:   rd_addr = AW'(nsat - 1'b1);
         S_RDN:   rd_addr = AW'(nsat - 1'b1);
         S_SRCH:  rd_addr = AW'(mid_ff);
         S_K1:    rd_addr = AW'(lo_ff + 1'b1);
         S_FDIV:  rd_addr = AW'(lo_ff + 1'b1);
         default: rd_addr = AW'(lo_ff);
      endcase
   end

   // Quotient and remainder with floor semantics from magnitude division
   always_comb begin
      q_s = 35'(drsp.quo);
      r_s = 35'(drsp.rem);
      if (d_ff[34]) begin
         if (r_s != 0) begin
            q_s = -q_s - 35'sd1;
            r_s = 35'(len_ff) - r_s;
         end else begin
            q_s = -q_s;
         end
      end
      case (wrap_mode_ff)
         WRAP_CLAMP:  off_v = d_ff[34] ? 35'sd0 :
                              (d_ff > 35'(len_ff) ? 35'(len_ff) : d_ff);
         WRAP_MIRROR: off_v = q_s[0] ? 35'(len_ff) - r_s : r_s;
         default:     off_v = r_s;
      endcase
   end

   assign diff_v = (w_ff > 35'(t_ff)) ? w_ff - 35'(t_ff) : 35'(t_ff) - w_ff;
   assign span_v = 35'($signed(rd_data_ff[31:0])) - 35'(k0_ff);
   assign frac_q = drsp.quo;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      out_data_in = out_data_ff;
      t_in = t_ff; start_in = start_ff; len_in = len_ff; d_in = d_ff;
      w_in = w_ff; k0_in = k0_ff; flat_in = flat_ff;
      lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff; cycle_in = cycle_ff;
      dreq = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready && req_tuser == KIND_QUERY) begin
               t_in = 33'($signed(req_tdata[37:6]));
               cycle_in = '0;
               if (nsat == '0) begin
                  out_data_in = {STATUS_EMPTY, 54'd0};
                  state_in    = S_OUT;
               end else begin
                  state_in = S_RD0;
               end
            end
         end
         S_RD0: begin
            // key 0 was read while idle
            start_in = 33'($signed(rd_data_ff[31:0]));
            state_in = S_RDN;
         end
         S_RDN: state_in = S_LEN;
         S_LEN: begin
            len_in = 34'($signed(rd_data_ff[31:0])) - 34'(start_ff);
            d_in   = 35'(t_ff) - 35'(start_ff);
            if (34'($signed(rd_data_ff[31:0])) - 34'(start_ff) <= 34'sd0) begin
               out_data_in = {STATUS_ZERO, 54'd0};
               state_in    = S_OUT;
            end else begin
               state_in = S_DIV;
               dreq.start = 1'b1;
               dreq.num = DIV_W'($unsigned((35'(t_ff) - 35'(start_ff)) < 0 ?
                          -(35'(t_ff) - 35'(start_ff)) : 35'(t_ff) - 35'(start_ff)));
               dreq.den = DIV_W'($unsigned(
                          34'($signed(rd_data_ff[31:0])) - 34'(start_ff)));
            end
         end
         S_DIV: if (drsp.done) state_in = S_WRAP;
         S_WRAP: begin
            w_in = 35'(start_ff) + off_v;
            if (wrap_mode_ff == WRAP_APPEND) begin
               cycle_in = (q_s > 35'sd2147483647) ? 32'sh7FFFFFFF :
                          (q_s < -35'sd2147483648) ? 32'sh80000000 : 32'(q_s);
            end
            d_in = off_v;  // keep offset for the snap test
            state_in = S_SNAP;
         end
         S_SNAP: begin
            if (d_ff > 0 && d_ff < 35'(len_ff) && diff_v < 35'(SNAP_TOLERANCE))
               w_in = 35'(t_ff);
            lo_in  = '0;
            hi_in  = nsat;
            mid_in = nsat >> 1;
            state_in = (nsat > NW'(1)) ? S_SRCH : S_SWAIT;
         end
         S_SRCH: state_in = S_SWAIT;  // read issued for mid
         S_SWAIT: begin
            if (hi_ff - lo_ff > NW'(1)) begin
               if (35'($signed(rd_data_ff[31:0])) <= w_ff) lo_in = mid_ff;
               else hi_in = mid_ff;
               if (35'($signed(rd_data_ff[31:0])) <= w_ff)
                  mid_in = mid_ff + ((hi_ff - mid_ff) >> 1);
               else
                  mid_in = lo_ff + ((mid_ff - lo_ff) >> 1);
               if (((35'($signed(rd_data_ff[31:0])) <= w_ff) ? hi_ff - mid_ff :
                    mid_ff - lo_ff) > NW'(1))
                  state_in = S_SRCH;
               else
                  state_in = S_K0;
            end else begin
               state_in = S_K0;
            end
         end
         S_K0: state_in = S_K1;  // read issued for lo
         S_K1: begin
            k0_in   = 33'($signed(rd_data_ff[31:0]));
            flat_in = rd_data_ff[32];
            state_in = S_FDIV;
         end
         S_FDIV: begin
            // rd_data now holds key lo+1
            out_data_in = {STATUS_OK, cycle_ff, 16'd0, 6'(lo_ff)};
            if (drsp.done) begin
               out_data_in[21:6] = (frac_q > DIV_W'(16'hFFFF)) ? 16'hFFFF :
                                   frac_q[15:0];
               state_in = S_OUT;
            end else if (!(lo_ff + 1'b1 < nsat) || flat_ff ||
                         35'(k0_ff) == w_ff || span_v <= 0 ||
                         w_ff <= 35'(k0_ff)) begin
               state_in = S_OUT;
            end else if (!dreq.start && mid_ff != '1) begin
               dreq.start = 1'b1;
               dreq.num = DIV_W'($unsigned(w_ff - 35'(k0_ff))) << 16;
               dreq.den = DIV_W'($unsigned(span_v));
               mid_in   = '1;   // marks the fraction divide as started
               state_in = S_FDIV;
            end
         end
         S_OUT: if (!out_valid_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Read of lo must land at S_K1: S_K0 addresses lo, S_K1 sees it
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT && !out_valid_ff) out_valid_ff <= 1'b1;
         else if (rsp_tvalid && rsp_tready)     out_valid_ff <= 1'b0;
      end
      out_data_ff <= out_data_in;
      t_ff <= t_in; start_ff <= start_in; len_ff <= len_in; d_ff <= d_in;
      w_ff <= w_in; k0_ff <= k0_in; flat_ff <= flat_in;
      lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in; cycle_ff <= cycle_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("item taken while busy");
   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWAIT) |-> lo_ff < hi_ff) else $error("search bounds crossed");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
`endif

endmodule
